// File: rtl/slri_pkg.sv
// slri_pkg: shared types and constants for the servo linear ramp interpolator.
// No dependencies; compiled first.
`default_nettype none

package slri_pkg;

    localparam int PWM_W       = 12;
    localparam int INC_W       = 13;
    localparam int PHASE_W     = 8;
    localparam int CHAN_IN_W   = 5;
    localparam int CHAN_OUT_W  = 4;
    localparam int REPORT_LIMIT = 15;
    localparam int PWM_MAX     = 4095;

    // reciprocal divide: q = (n * ceil(2^RECIP_SHIFT / STEPS)) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 20;
    localparam int MUL_B_W     = 21;
    localparam int PROD_W      = INC_W + 1 + MUL_B_W + 1;
    localparam int ACC_W       = 24;

    localparam int CHANNELS_DEF     = 18;
    localparam int STEPS_DEF        = 16;
    localparam int OUT_CHANNELS_DEF = 15;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    typedef enum logic [1:0] {
        MODE_RAMP,
        MODE_LAND,
        MODE_SEG
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  mul_en;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/slri_cmd_if.sv
// slri_cmd_if: valid/ready channel for command beats (target writes and ticks).
// Depends on slri_pkg.
`default_nettype none

interface slri_cmd_if import slri_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [CHAN_IN_W-1:0] channel;
    logic [PWM_W-1:0]     target_value;

    modport source (output valid, action, channel, target_value, input ready);
    modport sink   (input valid, action, channel, target_value, output ready);
endinterface

`default_nettype wire

// File: rtl/slri_res_if.sv
// slri_res_if: valid/ready channel for per-channel result beats.
// Depends on slri_pkg.
`default_nettype none

interface slri_res_if import slri_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAN_OUT_W-1:0] out_channel;
    logic [PWM_W-1:0]      pwm_count;
    logic                  segment_end;
    logic                  last_of_tick;

    modport source (output valid, out_channel, pwm_count, segment_end, last_of_tick,
                    input ready);
    modport sink   (input valid, out_channel, pwm_count, segment_end, last_of_tick,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/slri_alu.sv
// slri_alu: shared multiply / add / clamp unit used once per channel per tick.
// Depends on slri_pkg.
`default_nettype none

module slri_alu import slri_pkg::*; #(
    parameter int STEPS = STEPS_DEF
) (
    input  wire logic                    clk,
    input  wire alu_ctrl_t               ctrl,
    input  wire logic [PWM_W-1:0]        present,
    input  wire logic [PWM_W-1:0]        target,
    input  wire logic [PWM_W-1:0]        start,
    input  wire logic signed [INC_W-1:0] inc,
    output logic [PWM_W-1:0]             next_present,
    output logic signed [INC_W-1:0]      next_inc
);

    localparam logic [MUL_B_W-1:0] RECIP =
        MUL_B_W'(((1 << RECIP_SHIFT) + STEPS - 1) / STEPS);
    localparam logic [MUL_B_W-1:0] LAND_MULT = MUL_B_W'(STEPS - 1);
    localparam logic signed [ACC_W-1:0] PWM_TOP = ACC_W'(PWM_MAX);

    logic signed [PWM_W:0]   diff;
    logic                    diff_neg;
    logic [PWM_W-1:0]        diff_mag;
    logic signed [INC_W:0]   mul_a;
    logic signed [MUL_B_W:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    neg_reg;
    logic [PWM_W-1:0]        quot;
    logic signed [INC_W-1:0] quot_s;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] sum;

    // multiply step: |target - present| * reciprocal, or (STEPS-1) * increment
    always_comb
    begin
        diff     = signed'({1'b0, target}) - signed'({1'b0, present});
        diff_neg = diff[PWM_W];
        diff_mag = diff_neg ? PWM_W'(-diff) : diff[PWM_W-1:0];
        if (ctrl.mode == MODE_SEG)
        begin
            mul_a = signed'({2'b00, diff_mag});
            mul_b = signed'({1'b0, RECIP});
        end
        else
        begin
            mul_a = signed'({inc[INC_W-1], inc});
            mul_b = signed'({1'b0, LAND_MULT});
        end
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= product;
            neg_reg  <= diff_neg;
        end
    end

    // add step
    always_comb
    begin
        quot     = prod_reg[RECIP_SHIFT +: PWM_W];
        quot_s   = signed'({1'b0, quot});
        next_inc = neg_reg ? -quot_s : quot_s;

        if (ctrl.mode == MODE_LAND)
        begin
            addend = ACC_W'(signed'({1'b0, target})) - ACC_W'(signed'({1'b0, start}))
                     - signed'(prod_reg[ACC_W-1:0]);
        end
        else
        begin
            addend = ACC_W'(inc);
        end
        sum = ACC_W'(signed'({1'b0, present})) + addend;

        if (sum[ACC_W-1])
        begin
            next_present = '0;
        end
        else if (sum > PWM_TOP)
        begin
            next_present = PWM_W'(PWM_MAX);
        end
        else
        begin
            next_present = sum[PWM_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/servo_linear_ramp_interpolator.sv
// Servo linear ramp interpolator: per-channel target store and ramp sequencer.
// Depends on slri_pkg, slri_cmd_if, slri_res_if and slri_alu.
//
// A write beat (action=1) stores a target. A tick beat
// (action=0) walks every channel through the shared slri_alu and reports the
// pre-update count of the first min(OUT_CHANNELS, CHANNELS, 15) channels.
// During ramp phases each channel takes only an add step; on the landing
// phase and the segment-end tick each channel takes a multiply and an add
// step. A result beat waiting on res.ready stalls the walk only when the
// next report is due. cmd.ready is high only while no tick is in progress.
// No clearing pass after reset.
`default_nettype none

module servo_linear_ramp_interpolator import slri_pkg::*; #(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int STEPS        = STEPS_DEF,
    parameter int OUT_CHANNELS = OUT_CHANNELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    slri_cmd_if.sink   cmd,
    slri_res_if.source res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int N_REPORT_A = (OUT_CHANNELS < CHANNELS) ? OUT_CHANNELS : CHANNELS;
    localparam int N_REPORT = (N_REPORT_A < REPORT_LIMIT) ? N_REPORT_A : REPORT_LIMIT;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    logic [PWM_W-1:0]        target_store [CHANNELS];
    logic [PWM_W-1:0]        present_store [CHANNELS];
    logic [PWM_W-1:0]        start_store [CHANNELS];
    logic signed [INC_W-1:0] inc_store [CHANNELS];

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAN_OUT_W-1:0] out_chan_reg;
    logic [PWM_W-1:0]      out_pwm_reg;
    logic                  out_seg_reg;
    logic                  out_last_reg;

    logic      cmd_fire;
    logic      tgt_we;
    logic      ch_commit;
    logic      out_load;
    logic      report;
    logic      out_free;
    alu_ctrl_t alu_ctrl;
    logic [PWM_W-1:0]        alu_present;
    logic signed [INC_W-1:0] alu_inc;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign tgt_we    = cmd_fire && (cmd.action == ACT_WRITE)
                       && ({1'b0, cmd.channel} < (CHAN_IN_W + 1)'(CHANNELS));

    assign report   = ({1'b0, idx_reg} < (IDX_W + 1)'(N_REPORT));
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        ch_commit      = 1'b0;
        out_load       = 1'b0;
        alu_ctrl.mode   = mode_reg;
        alu_ctrl.mul_en = 1'b0;
        out_valid_next = out_valid_reg && !res.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.action == ACT_TICK))
                begin
                    idx_next = '0;
                    if (phase_reg >= PHASE_W'(STEPS))
                    begin
                        mode_next  = MODE_SEG;
                        state_next = ST_MUL;
                    end
                    else if (phase_reg == PHASE_W'(STEPS - 1))
                    begin
                        mode_next  = MODE_LAND;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        mode_next  = MODE_RAMP;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_MUL:
            begin
                alu_ctrl.mul_en = 1'b1;
                state_next      = ST_ADD;
            end
            ST_ADD:
            begin
                // hold the channel until its report beat has a free slot
                if (!report || out_free)
                begin
                    ch_commit = 1'b1;
                    out_load  = report;
                    if (report)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                        phase_next = (mode_reg == MODE_SEG) ? '0 : phase_reg + 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = (mode_reg == MODE_RAMP) ? ST_ADD : ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    slri_alu #(
        .STEPS (STEPS)
    ) u_alu (
        .clk          (clk),
        .ctrl         (alu_ctrl),
        .present      (present_store[idx_reg]),
        .target       (target_store[idx_reg]),
        .start        (start_store[idx_reg]),
        .inc          (inc_store[idx_reg]),
        .next_present (alu_present),
        .next_inc     (alu_inc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RAMP;
            idx_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                target_store[i]  <= '0;
                present_store[i] <= '0;
                start_store[i]   <= '0;
                inc_store[i]     <= '0;
            end
        end
        else
        begin
            if (tgt_we)
            begin
                target_store[cmd.channel[IDX_W-1:0]] <= cmd.target_value;
            end
            if (ch_commit)
            begin
                if (mode_reg == MODE_SEG)
                begin
                    start_store[idx_reg] <= present_store[idx_reg];
                    inc_store[idx_reg]   <= alu_inc;
                end
                else
                begin
                    present_store[idx_reg] <= alu_present;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_chan_reg <= CHAN_OUT_W'(idx_reg);
            out_pwm_reg  <= present_store[idx_reg];
            out_seg_reg  <= (mode_reg == MODE_SEG);
            out_last_reg <= ({1'b0, idx_reg} == (IDX_W + 1)'(N_REPORT - 1));
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.out_channel  = out_chan_reg;
    assign res.pwm_count    = out_pwm_reg;
    assign res.segment_end  = out_seg_reg;
    assign res.last_of_tick = out_last_reg;

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_W'(STEPS))
        else $error("phase count ran past STEPS");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.action == ACT_TICK)) |=> (state_reg != ST_IDLE))
        else $error("tick beat did not start the channel walk");

    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last_of_tick) |-> (res.out_channel == CHAN_OUT_W'(N_REPORT - 1)))
        else $error("last_of_tick on wrong channel");

    a_walk_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ADD) && ch_commit && (idx_reg == IDX_LAST)) |=>
            (state_reg == ST_IDLE))
        else $error("walk did not return to idle after the last channel");

endmodule

`default_nettype wire
